### rtl/core/spq_pkg.sv
// Shared constants, codes and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int COST_WIDTH  = 16;
  localparam int ID_WIDTH    = 8;
  localparam int IDX_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  // Port field widths
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int PCOST_W  = 16;
  localparam int PCNT_W   = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Cell commands
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_ADD,       // insert behind equal costs
    CMD_REINS,     // insert a changed entry, tail-aware compare
    CMD_EXT_HEAD,  // pull out cell 0, shift left
    CMD_EXT_ID     // pull out first id match, shift left
  } cell_cmd_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]   id;
    logic [COST_WIDTH-1:0] cost;
  } entry_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [ID_WIDTH-1:0]   id;
    logic [COST_WIDTH-1:0] cost;
    logic [CNT_WIDTH-1:0]  limit;  // occupied cells
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/spq_if.sv
// Valid/ready channel interfaces for queue requests and responses.
`default_nettype none
interface spq_req_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::OP_W-1:0]      operation;
  logic [spq_pkg::ID_WIDTH-1:0]  entry_id;
  logic [spq_pkg::PCOST_W-1:0]   entry_cost;

  modport source (output valid, output operation, output entry_id, output entry_cost,
                  input ready);
  modport sink   (input valid, input operation, input entry_id, input entry_cost,
                  output ready);
endinterface

interface spq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::ID_WIDTH-1:0]  out_id;
  logic [spq_pkg::PCOST_W-1:0]   out_cost;
  logic [spq_pkg::PCNT_W-1:0]    queue_count;

  modport source (output valid, output status, output out_id, output out_cost,
                  output queue_count, input ready);
  modport sink   (input valid, input status, input out_id, input out_cost,
                  input queue_count, output ready);
endinterface
`default_nettype wire

### rtl/core/spq_cell.sv
// One queue slot: compare against the key and take data from a neighbor.
`default_nettype none
module spq_cell (
  input  wire logic                       clk,
  input  wire spq_pkg::cell_ctl_t         ctl,
  input  wire logic [spq_pkg::IDX_WIDTH-1:0] idx,
  input  wire spq_pkg::entry_t            left_data,
  input  wire logic                       left_ahead,
  input  wire logic                       left_seen,
  input  wire spq_pkg::entry_t            right_data,
  output spq_pkg::entry_t                 data,
  output logic                            ahead,
  output logic                            seen
);
  import spq_pkg::*;

  logic   tail;
  logic   occ;
  logic   hit;
  logic   le;
  logic   lt;
  entry_t data_next;
  logic   tail_next;

  assign occ = {1'b0, idx} < ctl.limit;
  assign hit = occ && (((ctl.cmd == CMD_EXT_HEAD) && (idx == '0)) ||
                       ((ctl.cmd == CMD_EXT_ID) && (data.id == ctl.id)));
  assign seen = left_seen || hit;
  assign le = data.cost <= ctl.cost;
  assign lt = data.cost < ctl.cost;
  // cells that came from behind the changed entry also yield to equal costs
  assign ahead = occ && (((ctl.cmd == CMD_REINS) && tail) ? lt : le);

  always_comb begin
    data_next = data;
    tail_next = tail;
    unique case (ctl.cmd)
      CMD_ADD, CMD_REINS: begin
        if (!ahead) begin
          if (left_ahead) begin
            data_next = '{id: ctl.id, cost: ctl.cost};
          end else begin
            data_next = left_data;
          end
        end
      end
      CMD_EXT_HEAD, CMD_EXT_ID: begin
        if (seen) begin
          data_next = right_data;
        end
        tail_next = seen;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    tail <= tail_next;
  end

endmodule
`default_nettype wire

### rtl/core/spq_cell_array.sv
// Row of queue cells, each wired to its left and right neighbor.
`default_nettype none
module spq_cell_array (
  input  wire logic                clk,
  input  wire spq_pkg::cell_ctl_t  ctl,
  output spq_pkg::entry_t          head,
  output logic                     found
);
  import spq_pkg::*;

  entry_t cell_data   [QUEUE_DEPTH];
  logic   cell_ahead  [QUEUE_DEPTH];
  logic   cell_seen   [QUEUE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t l_data;
      logic   l_ahead;
      logic   l_seen;
      entry_t r_data;

      if (i == 0) begin : g_first
        assign l_data   = '{id: ctl.id, cost: ctl.cost};
        assign l_ahead  = 1'b1;
        assign l_seen   = 1'b0;
      end else begin : g_mid
        assign l_data   = cell_data[i-1];
        assign l_ahead  = cell_ahead[i-1];
        assign l_seen   = cell_seen[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign r_data = cell_data[i];
      end else begin : g_inner
        assign r_data = cell_data[i+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .idx         (IDX_WIDTH'(i)),
        .left_data   (l_data),
        .left_ahead  (l_ahead),
        .left_seen   (l_seen),
        .right_data  (r_data),
        .data        (cell_data[i]),
        .ahead       (cell_ahead[i]),
        .seen        (cell_seen[i])
      );
    end
  endgenerate

  assign head  = cell_data[0];
  assign found = cell_seen[QUEUE_DEPTH-1];

endmodule
`default_nettype wire

### rtl/core/sorted_priority_queue.sv
// Top level: sorted priority queue built from a row of compare-and-shift cells.
// A result beat is loaded into the response register from S_REPORT after acceptance;
//   a change that finds its id goes through S_INS first (pull-out pass, then re-insert
//   pass through the cell row). A new request is taken only after the last result is
//   loaded; a result waiting on rsp.ready holds the next one and, behind it, the input.
// Reset: entry count 0, control idle, no response pending; cell contents undefined.
`default_nettype none
module sorted_priority_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  spq_req_if.sink     req,
  spq_rsp_if.source   rsp
);
  import spq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INS    = 2'd1;  // re-insert of a changed entry
  localparam logic [1:0] S_REPORT = 2'd2;  // load response register

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [CNT_WIDTH-1:0]  count;
  logic [CNT_WIDTH-1:0]  count_next;
  logic [ID_WIDTH-1:0]   key_id;
  logic [COST_WIDTH-1:0] key_cost;
  logic [STATUS_W-1:0]   status;
  logic [STATUS_W-1:0]   status_next;
  logic                  removed;
  logic                  removed_next;
  entry_t                rem;

  cell_ctl_t ctl;
  entry_t    head;
  logic      found;
  logic      accept;
  logic      rsp_free;
  logic [COST_WIDTH-1:0] in_cost;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp_free = !rsp.valid || rsp.ready;
  assign in_cost  = COST_WIDTH'(req.entry_cost);

  spq_cell_array u_row (
    .clk   (clk),
    .ctl   (ctl),
    .head  (head),
    .found (found)
  );

  // Command for the cell row and next control state
  always_comb begin
    ctl.cmd      = CMD_HOLD;
    ctl.id       = req.entry_id;
    ctl.cost     = in_cost;
    ctl.limit    = count;
    state_next   = state;
    count_next   = count;
    status_next  = status;
    removed_next = removed;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next  = ST_OK;
          removed_next = 1'b0;
          state_next   = S_REPORT;
          unique case (req.operation)
            OP_ADD: begin
              if (count == CNT_WIDTH'(QUEUE_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                ctl.cmd    = CMD_ADD;
                count_next = count + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                ctl.cmd      = CMD_EXT_HEAD;
                count_next   = count - 1'b1;
                removed_next = 1'b1;
              end
            end
            OP_CHANGE: begin
              // pull the first matching entry out; cells behind it close the gap
              ctl.cmd = CMD_EXT_ID;
              if (found) begin
                state_next = S_INS;
              end else begin
                status_next = ST_NOTFOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        // row holds one fewer entry until the changed one goes back in
        ctl.cmd    = CMD_REINS;
        ctl.id     = key_id;
        ctl.cost   = key_cost;
        ctl.limit  = count - 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      status  <= ST_OK;
      removed <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      status  <= status_next;
      removed <= removed_next;
    end
  end

  // Request payload kept for the re-insert pass and the removed entry
  always_ff @(posedge clk) begin
    if (accept) begin
      key_id   <= req.entry_id;
      key_cost <= in_cost;
      rem      <= head;
    end
  end

  // Response register: a finished beat waits here while the next request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_REPORT) && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_REPORT) && rsp_free) begin
      rsp.status      <= status;
      rsp.queue_count <= PCNT_W'(count);
      if (removed) begin
        rsp.out_id   <= rem.id;
        rsp.out_cost <= PCOST_W'(rem.cost);
      end else if (count != '0) begin
        rsp.out_id   <= head.id;
        rsp.out_cost <= PCOST_W'(head.cost);
      end else begin
        rsp.out_id   <= '0;
        rsp.out_cost <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### dv/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: random op stream, scoreboard on replies.
`default_nettype none
module tb_sorted_priority_queue;
  import spq_pkg::*;

  // Operation code the block treats as a no-op (reports head, changes nothing).
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 12;
  localparam int TAIL_ITEMS   = 200;   // last stretch of the run runs without idling
  localparam int LONG_HOLD    = 600;   // one long receiver hold-off to back up the input
  localparam int HOLD_AT      = 300;   // reply count that triggers the long hold-off
  localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 16;    // wait after the last reply before finishing

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ID_WIDTH-1:0] id;
    logic [PCOST_W-1:0]  cost;
  } queue_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_WIDTH-1:0] id;
    logic [PCOST_W-1:0]  cost;
    logic [PCNT_W-1:0]   count;
  } queue_reply_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Shadow copy of the sorted list; only slots below held_count are meaningful.
  entry_t      shadow_list [QUEUE_DEPTH];
  int unsigned held_count;

  queue_op_t    pending_ops [$];
  queue_reply_t reply_due [$];

  int unsigned total_items;
  int unsigned accepted_count;
  int unsigned replies_seen;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          held_off;
  bit          quiet_tail;
  bit          timed_out;
  queue_reply_t want;
  queue_reply_t got;
  queue_op_t    next_op;

  // Apply one operation to the shadow list and return the reply it should produce.
  function automatic queue_reply_t apply_queue_op(queue_op_t qop);
    queue_reply_t r;
    entry_t       tmp;
    int unsigned  pos;
    int unsigned  k;
    int unsigned  i;
    bit           removed;
    bit           hit;
    r = '0;
    removed = 1'b0;
    hit = 1'b0;
    case (qop.op)
      OP_ADD: begin
        if (held_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or lower cost
          pos = 0;
          while (pos < held_count && shadow_list[pos].cost <= qop.cost[COST_WIDTH-1:0])
            pos++;
          for (k = held_count; k > pos; k--)
            shadow_list[k] = shadow_list[k-1];
          shadow_list[pos].id   = qop.id;
          shadow_list[pos].cost = qop.cost[COST_WIDTH-1:0];
          held_count++;
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_OK;
          r.id     = shadow_list[0].id;
          r.cost   = PCOST_W'(shadow_list[0].cost);
          for (k = 1; k < held_count; k++)
            shadow_list[k-1] = shadow_list[k];
          held_count--;
          removed = 1'b1;
        end
      end
      OP_CHANGE: begin
        // first match from the head takes the new cost
        for (i = 0; i < held_count && !hit; i++) begin
          if (shadow_list[i].id == qop.id) begin
            shadow_list[i].cost = qop.cost[COST_WIDTH-1:0];
            hit = 1'b1;
          end
        end
        if (hit) begin
          // stable insertion sort: only strictly lower costs move forward
          for (i = 1; i < held_count; i++) begin
            k = i;
            while (k > 0 && shadow_list[k].cost < shadow_list[k-1].cost) begin
              tmp              = shadow_list[k];
              shadow_list[k]   = shadow_list[k-1];
              shadow_list[k-1] = tmp;
              k--;
            end
          end
          r.status = ST_OK;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: r.status = ST_OK;
    endcase
    if (!removed && held_count > 0) begin
      r.id   = shadow_list[0].id;
      r.cost = PCOST_W'(shadow_list[0].cost);
    end
    r.count = PCNT_W'(held_count);
    return r;
  endfunction

  task automatic push_op(logic [OP_W-1:0] op, logic [ID_WIDTH-1:0] id,
                         logic [PCOST_W-1:0] cost);
    queue_op_t qop;
    qop.op   = op;
    qop.id   = id;
    qop.cost = cost;
    pending_ops.push_back(qop);
  endtask

  // Weighted random ops; ids mostly from a small pool so changes hit, costs tie often.
  task automatic push_random(int unsigned n, int unsigned add_w, int unsigned rem_w,
                             int unsigned chg_w);
    int unsigned        roll;
    logic [OP_W-1:0]    op;
    logic [ID_WIDTH-1:0] id;
    logic [PCOST_W-1:0] cost;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < add_w)                       op = OP_ADD;
      else if (roll < add_w + rem_w)          op = OP_REMOVE;
      else if (roll < add_w + rem_w + chg_w)  op = OP_CHANGE;
      else                                    op = OP_UNUSED;
      if ($urandom_range(0, 9) < 7) id = ID_WIDTH'($urandom_range(0, 15));
      else                          id = ID_WIDTH'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 4)       cost = PCOST_W'($urandom_range(0, 7));
      else if (roll == 4) cost = $urandom_range(0, 1) ? '1 : '0;
      else                cost = PCOST_W'($urandom);
      push_op(op, id, cost);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Main sequence: build the op list, reset once, wait for the scoreboard to empty.
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.operation  = '0;
    req_ch.entry_id   = '0;
    req_ch.entry_cost = '0;
    rsp_ch.ready      = 1'b0;
    held_count        = 0;
    accepted_count    = 0;
    replies_seen      = 0;
    error_count       = 0;
    idle_cycles       = 0;
    timed_out         = 1'b0;

    // Directed: empty-list corner cases first
    push_op(OP_REMOVE, 8'd0,   16'd0);       // remove on empty
    push_op(OP_CHANGE, 8'd5,   16'd9);       // change on empty: not found
    push_op(OP_UNUSED, 8'd255, 16'hFFFF);    // unused code on empty
    // cost and id extremes, then a run of ties
    push_op(OP_ADD,    8'd0,   16'hFFFF);
    push_op(OP_ADD,    8'd255, 16'd0);
    push_op(OP_ADD,    8'd10,  16'd100);
    push_op(OP_ADD,    8'd11,  16'd100);
    push_op(OP_ADD,    8'd12,  16'd100);
    push_op(OP_CHANGE, 8'd10,  16'd100);     // same cost: keeps place among ties
    push_op(OP_CHANGE, 8'd11,  16'd50);      // lower cost: moves forward
    push_op(OP_CHANGE, 8'd255, 16'hFFFF);    // head to max cost, ties with id 0
    push_op(OP_CHANGE, 8'd77,  16'd1);       // no such id
    push_op(OP_UNUSED, 8'd0,   16'd0);       // unused code on a non-empty list
    push_op(OP_ADD,    8'd0,   16'd100);     // duplicate id
    push_op(OP_CHANGE, 8'd0,   16'd1);       // first id match from the head wins
    push_op(OP_CHANGE, 8'd12,  16'd0);       // a middle entry to the head
    repeat (7) push_op(OP_REMOVE, 8'd0, 16'd0);  // drain plus one on empty

    // Random: fill to full (adds refused), drain to empty, then a balanced mix
    push_random(450, 80, 10, 8);
    push_random(450, 10, 80, 8);
    push_random(600, 40, 35, 22);
    total_items = pending_ops.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && !(accepted_count == total_items && reply_due.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT)
        timed_out = 1'b1;
    end
    if (!timed_out)
      repeat (DRAIN_CYCLES) @(posedge clk);
    if (!timed_out && error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Driver: one op per beat from pending_ops, with random idle gaps between beats.
  // The reply for each accepted beat is predicted right at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= '0;
      req_ch.entry_id   <= '0;
      req_ch.entry_cost <= '0;
      gap_left          <= 0;
      quiet_tail        <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        next_op.op   = req_ch.operation;
        next_op.id   = req_ch.entry_id;
        next_op.cost = req_ch.entry_cost;
        reply_due.push_back(apply_queue_op(next_op));
        accepted_count <= accepted_count + 1;
      end
      quiet_tail <= (pending_ops.size() < TAIL_ITEMS);
      // a held beat stays untouched until it is taken
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          gap_left     <= $urandom_range(0, 12);
          req_ch.valid <= 1'b0;
        end else begin
          next_op            = pending_ops.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.operation  <= next_op.op;
          req_ch.entry_id   <= next_op.id;
          req_ch.entry_cost <= next_op.cost;
        end
      end
    end
  end

  // Monitor: checks each reply beat against the oldest prediction and drives ready.
  // Ready drops in random bursts, plus one long hold-off so the block backs up
  // and has to stall its input while the driver keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 0;
      held_off     <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.id     = rsp_ch.out_id;
        got.cost   = rsp_ch.out_cost;
        got.count  = rsp_ch.queue_count;
        replies_seen <= replies_seen + 1;
        if (reply_due.size() == 0) begin
          error_count <= error_count + 1;
          $display("%0t: unexpected reply status=%0d id=%0d cost=%0d count=%0d",
                   $time, got.status, got.id, got.cost, got.count);
        end else begin
          want = reply_due.pop_front();
          if (got.status != want.status || got.id != want.id ||
              got.cost != want.cost || got.count != want.count) begin
            error_count <= error_count + 1;
            $display("%0t: reply mismatch exp status=%0d id=%0d cost=%0d count=%0d",
                     $time, want.status, want.id, want.cost, want.count);
            $display("%0t:                got status=%0d id=%0d cost=%0d count=%0d",
                     $time, got.status, got.id, got.cost, got.count);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!held_off && replies_seen >= HOLD_AT) begin
        held_off     <= 1'b1;
        hold_left    <= LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        hold_left    <= $urandom_range(0, 12);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: consecutive cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_cell.sv
rtl/core/spq_cell_array.sv
rtl/core/sorted_priority_queue.sv
dv/tb_sorted_priority_queue.sv
